FILE: rtl/urlpd_pkg.sv
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types and constants of the percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package urlpd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [1:0] HELD_NONE    = 2'd0;
    localparam logic [1:0] HELD_PERCENT = 2'd1;
    localparam logic [1:0] HELD_DIGIT   = 2'd2;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic       last0;
        logic [7:0] byte1;
        logic       last1;
    } urlpd_res_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } urlpd_hex_t;

    function automatic urlpd_hex_t hex_decode(input logic [7:0] b);
        urlpd_hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/urlpd_step.sv
// ----------------------------------------------------------------------------
// urlpd_step
// Decode step: from the held state and one input byte, form the next held
// state and the zero to two decoded bytes of this transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module urlpd_step
    import urlpd_pkg::*;
(
    input  wire logic [1:0] held_count,
    input  wire logic [3:0] held_digit,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output      logic [1:0] next_count,
    output      logic       digit_we,
    output      logic [3:0] digit_value,
    output      urlpd_res_t res
);

    urlpd_hex_t hex;
    logic       fresh_last;
    logic       fresh_emit;
    logic       fresh_hold;
    logic [7:0] fresh_byte;

    assign hex         = hex_decode(in_byte);
    assign digit_value = hex.value;

    always_comb
    begin
        fresh_last = in_last;
        fresh_emit = 1'b1;
        fresh_hold = 1'b0;
        fresh_byte = in_byte;
        if (in_byte == CH_PLUS) begin
            fresh_byte = CH_SPACE;
        end else if (in_byte == CH_PERCENT && !fresh_last) begin
            fresh_emit = 1'b0;
            fresh_hold = 1'b1;
        end
    end

    always_comb
    begin
        next_count = HELD_NONE;
        digit_we   = 1'b0;
        res.count  = 2'd0;
        res.byte0  = fresh_byte;
        res.last0  = in_last;
        res.byte1  = fresh_byte;
        res.last1  = in_last;
        unique case (held_count)
            HELD_PERCENT:
            begin
                if (!in_last && hex.valid) begin
                    next_count = HELD_DIGIT;
                    digit_we   = 1'b1;
                end else begin
                    res.byte0  = CH_PERCENT;
                    res.last0  = 1'b0;
                    res.count  = fresh_emit ? 2'd2 : 2'd1;
                    next_count = fresh_hold ? HELD_PERCENT : HELD_NONE;
                end
            end
            HELD_DIGIT:
            begin
                res.count = 2'd1;
                res.byte0 = hex.valid ? {held_digit, hex.value} : {4'd0, held_digit};
            end
            default:
            begin
                res.count  = fresh_emit ? 2'd1 : 2'd0;
                next_count = fresh_hold ? HELD_PERCENT : HELD_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming form-urlencoded percent decoder, one byte per transaction.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_byte and in_last (final byte of a
// string). Output channel: out_valid/out_stall with out_byte and out_last.
// A plus becomes a space; a percent, a hex digit and a byte are decoded.
// Each input transaction yields zero, one or two output bytes, written into
// a four-entry result queue at the accepting edge, so from an empty queue the
// first of them is offered in the next cycle.
// The input takes one byte per cycle while the queue has room for two
// results; with out_stall low, sustained throughput is one input byte per
// cycle when each byte gives at most one result, and is bound by the output
// port at one result per cycle otherwise. in_stall rises when the queue
// holds three or more results, so a stalled receiver backs up into the input.
// Reset empties the queue and clears the held percent state.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder
    import urlpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [7:0] out_byte,
    output      logic       out_last
);

    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [3:0] held_digit_reg;
    logic       digit_we;
    logic [3:0] digit_value;
    urlpd_res_t res;

    logic [8:0] queue_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       push;
    logic       pop;
    logic [1:0] push_n;

    urlpd_step u_step (
        .held_count  (held_count_reg),
        .held_digit  (held_digit_reg),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .next_count  (held_count_next),
        .digit_we    (digit_we),
        .digit_value (digit_value),
        .res         (res)
    );

    assign in_stall  = (count_reg > 3'd2);
    assign push      = in_valid && !in_stall;
    assign push_n    = push ? res.count : 2'd0;
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && !out_stall;
    assign out_byte  = queue_reg[rd_ptr_reg][8:1];
    assign out_last  = queue_reg[rd_ptr_reg][0];
    assign count_next = count_reg + {1'b0, push_n} - {2'd0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_count_reg <= HELD_NONE;
            wr_ptr_reg     <= 2'd0;
            rd_ptr_reg     <= 2'd0;
            count_reg      <= 3'd0;
        end else begin
            if (push) begin
                held_count_reg <= held_count_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && digit_we) begin
            held_digit_reg <= digit_value;
        end
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= {res.byte0, res.last0};
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_reg + 2'd1] <= {res.byte1, res.last1};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/urlpd_checker.sv
// ----------------------------------------------------------------------------
// urlpd_checker
// Port-level checks of the percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module urlpd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] in_byte,
    input wire logic       in_last,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled output transaction changed");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_last |=> out_valid)
        else $error("final input byte gave no output");

    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output pending");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
        else $error("stalled input transaction changed");

endmodule

bind url_percent_decoder urlpd_checker u_urlpd_checker (.*);

`default_nettype wire
